// ----- rtl/bq_pkg.sv -----
package bq_pkg;

    localparam int COEF_WIDTH          = 24;
    localparam int DELAY_WIDTH         = 48;
    localparam int SAMPLE_WIDTH_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF  = 20;
    localparam int CFG_INDEX_WIDTH     = 3;

    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    localparam t_cfg_index CFG_B0 = 3'd0;
    localparam t_cfg_index CFG_B1 = 3'd1;
    localparam t_cfg_index CFG_B2 = 3'd2;
    localparam t_cfg_index CFG_A1 = 3'd3;
    localparam t_cfg_index CFG_A2 = 3'd4;

    typedef logic [1:0] t_acc_op;

    localparam t_acc_op ACC_HOLD = 2'd0;
    localparam t_acc_op ACC_LOAD = 2'd1;
    localparam t_acc_op ACC_SUB  = 2'd2;

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctl;

endpackage

// ----- rtl/bq_mac.sv -----
module bq_mac #(
    parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = bq_pkg::DELAY_WIDTH + 3
) (
    input  logic                                i_clk,
    input  bq_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [bq_pkg::COEF_WIDTH-1:0] i_coef,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_operand,
    input  logic signed [ACC_WIDTH-1:0]         i_addend,
    output logic signed [ACC_WIDTH-1:0]         o_acc
);

    localparam int PROD_WIDTH = bq_pkg::COEF_WIDTH + SAMPLE_WIDTH;

    logic signed [PROD_WIDTH-1:0] r_prod;
    logic signed [ACC_WIDTH-1:0]  r_acc;
    logic signed [ACC_WIDTH-1:0]  prod_ext;

    assign prod_ext = {{(ACC_WIDTH-PROD_WIDTH){r_prod[PROD_WIDTH-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_coef * i_operand;
        end
        case (i_ctl.acc_op)
            bq_pkg::ACC_LOAD: r_acc <= prod_ext + i_addend;
            bq_pkg::ACC_SUB:  r_acc <= r_acc - prod_ext;
            default:          r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/biquad_iir_filter.sv -----
// Channel   Direction  Payload
// s_axis    in         tdata: sample_in; tuser: restart
// m_axis    out        tdata: sample_out; tuser: clipped
// cfg       in         index 0..4 = b0, b1, b2, a1, a2; data: coefficient
//
// Each sample runs through the input transfer plus 8 sequencer steps
// that run all five products through one multiplier. The result is
// written to the output register at the last step, D2; the next input transfer is taken back in idle.
// s_axis_tready is high only while the sequencer is idle.
// A result waiting in the output register does not block the next sample;
// the last step holds only if a previous result still waits.
// Reset (synchronous, active low) restores coefficients and clears delays.
module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF,
    localparam int TDATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [TDATA_WIDTH-1:0]             s_axis_tdata,  // sample_in
    input  logic [0:0]                         s_axis_tuser,  // restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [TDATA_WIDTH-1:0]             m_axis_tdata,  // sample_out
    output logic [0:0]                         m_axis_tuser,  // clipped
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bq_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [bq_pkg::COEF_WIDTH-1:0]      i_cfg_data
);

    localparam int CW     = bq_pkg::COEF_WIDTH;
    localparam int DW     = bq_pkg::DELAY_WIDTH;
    localparam int PROD_W = CW + SAMPLE_WIDTH;
    localparam int ACC_W  = ((PROD_W > DW) ? PROD_W : DW) + 3;

    localparam logic signed [ACC_W-1:0] ACC_RND =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_HI =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;
    localparam logic signed [ACC_W-1:0] D_HI =
        {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] D_LO = ~D_HI;
    localparam logic [CW-1:0] COEF_ONE = {{(CW-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_M0   = 4'd1;
    localparam logic [3:0] ST_A0   = 4'd2;
    localparam logic [3:0] ST_Y    = 4'd3;
    localparam logic [3:0] ST_M1   = 4'd4;
    localparam logic [3:0] ST_S1   = 4'd5;
    localparam logic [3:0] ST_D1   = 4'd6;
    localparam logic [3:0] ST_S2   = 4'd7;
    localparam logic [3:0] ST_D2   = 4'd8;

    logic [3:0]                     r_step, n_step;
    logic signed [CW-1:0]           r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [DW-1:0]           r_d1, r_d2;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y;
    logic                           r_clip;
    logic                           r_out_valid;
    logic [SAMPLE_WIDTH-1:0]        r_out_sample;
    logic                           r_out_clip;

    bq_pkg::t_mac_ctl               mac_ctl;
    logic signed [CW-1:0]           mac_coef;
    logic signed [SAMPLE_WIDTH-1:0] mac_operand;
    logic signed [ACC_W-1:0]        mac_addend;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        y_shift;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_clip;
    logic signed [DW-1:0]           d_sat;
    logic                           in_xfer;
    logic                           out_free;

    assign s_axis_tready = (r_step == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign y_shift = acc >>> COEF_FRAC_BITS;

    always_comb begin
        y_clip = 1'b0;
        y_sat  = y_shift[SAMPLE_WIDTH-1:0];
        if (y_shift > Y_HI) begin
            y_sat  = Y_HI[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end else if (y_shift < Y_LO) begin
            y_sat  = Y_LO[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end
    end

    always_comb begin
        d_sat = acc[DW-1:0];
        if (acc > D_HI) begin
            d_sat = D_HI[DW-1:0];
        end else if (acc < D_LO) begin
            d_sat = D_LO[DW-1:0];
        end
    end

    always_comb begin
        mac_ctl     = '{mul_en: 1'b0, acc_op: bq_pkg::ACC_HOLD};
        mac_coef    = r_b0;
        mac_operand = r_x;
        mac_addend  = '0;
        n_step      = r_step;
        case (r_step)
            ST_IDLE: begin
                if (in_xfer) n_step = ST_M0;
            end
            ST_M0: begin
                mac_ctl.mul_en = 1'b1;
                n_step         = ST_A0;
            end
            ST_A0: begin
                mac_ctl     = '{mul_en: 1'b1, acc_op: bq_pkg::ACC_LOAD};
                mac_coef    = r_b1;
                mac_addend  = {{(ACC_W-DW){r_d1[DW-1]}}, r_d1} + ACC_RND;
                n_step      = ST_Y;
            end
            ST_Y: begin
                mac_ctl.acc_op = bq_pkg::ACC_LOAD;
                mac_addend     = {{(ACC_W-DW){r_d2[DW-1]}}, r_d2};
                n_step         = ST_M1;
            end
            ST_M1: begin
                mac_ctl.mul_en = 1'b1;
                mac_coef       = r_a1;
                mac_operand    = r_y;
                n_step         = ST_S1;
            end
            ST_S1: begin
                mac_ctl  = '{mul_en: 1'b1, acc_op: bq_pkg::ACC_SUB};
                mac_coef = r_b2;
                n_step   = ST_D1;
            end
            ST_D1: begin
                mac_ctl     = '{mul_en: 1'b1, acc_op: bq_pkg::ACC_LOAD};
                mac_coef    = r_a2;
                mac_operand = r_y;
                n_step      = ST_S2;
            end
            ST_S2: begin
                mac_ctl.acc_op = bq_pkg::ACC_SUB;
                n_step         = ST_D2;
            end
            ST_D2: begin
                if (out_free) n_step = ST_IDLE;
            end
            default: n_step = ST_IDLE;
        endcase
    end

    bq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctl     (mac_ctl),
        .i_coef    (mac_coef),
        .i_operand (mac_operand),
        .i_addend  (mac_addend),
        .o_acc     (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_d1        <= '0;
            r_d2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (in_xfer && s_axis_tuser[0]) begin
                r_d1 <= '0;
                r_d2 <= '0;
            end
            if (r_step == ST_D1) r_d1 <= d_sat;
            if (r_step == ST_D2) r_d2 <= d_sat;
            if (r_step == ST_D2 && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) r_x <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        if (r_step == ST_Y) begin
            r_y    <= y_sat;
            r_clip <= y_clip;
        end
        if (r_step == ST_D2 && out_free) begin
            r_out_sample <= r_y;
            r_out_clip   <= r_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bq_pkg::CFG_B0: r_b0 <= i_cfg_data;
                bq_pkg::CFG_B1: r_b1 <= i_cfg_data;
                bq_pkg::CFG_B2: r_b2 <= i_cfg_data;
                bq_pkg::CFG_A1: r_a1 <= i_cfg_data;
                bq_pkg::CFG_A2: r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = TDATA_WIDTH'(r_out_sample);
    assign m_axis_tuser[0] = r_out_clip;

    a_start_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_step == ST_M0)
        else $error("sequencer did not start after input transfer");

    a_result_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_step) == ST_D2)
        else $error("result appeared outside the last step");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (r_out_sample == Y_HI[SAMPLE_WIDTH-1:0] ||
             r_out_sample == Y_LO[SAMPLE_WIDTH-1:0]))
        else $error("clipped result is not at a range limit");

endmodule
